### rtl/core/a64ls_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the load/store class decoder
// no dependencies; used by a64ls_classify and the top level
package a64ls_pkg;

  localparam int unsigned WordWidth  = 32;
  localparam int unsigned ClassWidth = 4;

  // result class codes
  typedef enum logic [ClassWidth-1:0] {
    CLS_UNALLOC = 4'd0,
    CLS_UNMODEL = 4'd1,
    CLS_NOP     = 4'd2,
    CLS_STORE   = 4'd3,
    CLS_LOAD    = 4'd4,
    CLS_LDP     = 4'd5,
    CLS_STP     = 4'd6,
    CLS_LIT     = 4'd7,
    CLS_STXR    = 4'd8,
    CLS_CAS     = 4'd9,
    CLS_LDXR    = 4'd10,
    CLS_STRL    = 4'd11,
    CLS_LDAQ    = 4'd12
  } cls_e;

  // encoding group codes, word bits 29:24
  localparam logic [5:0] FORM_EXCL     = 6'h08;
  localparam logic [5:0] FORM_LIT_GP   = 6'h18;
  localparam logic [5:0] FORM_LIT_VEC  = 6'h1c;
  localparam logic [5:0] FORM_PAIR_0   = 6'h28;
  localparam logic [5:0] FORM_PAIR_1   = 6'h29;
  localparam logic [5:0] FORM_PAIR_2   = 6'h2c;
  localparam logic [5:0] FORM_PAIR_3   = 6'h2d;
  localparam logic [5:0] FORM_REG_0    = 6'h38;
  localparam logic [5:0] FORM_REG_1    = 6'h39;
  localparam logic [5:0] FORM_REG_2    = 6'h3c;
  localparam logic [5:0] FORM_REG_3    = 6'h3d;
  localparam logic [5:0] FORM_SIMD_0   = 6'h0c;
  localparam logic [5:0] FORM_SIMD_1   = 6'h0d;

  // register field value meaning "no second register"
  localparam logic [4:0] RT_NONE = 5'd31;

  // size / opc field codes
  localparam logic [1:0] SIZE_DWORD    = 2'b11;
  localparam logic [1:0] OPC_STORE     = 2'b00;
  localparam logic [1:0] OPC_SIGNED64  = 2'b10;
  localparam logic [1:0] OPC_SIGNED32  = 2'b11;
  localparam logic [1:0] OPTION_ROFF   = 2'b10;

endpackage

### rtl/core/a64ls_stage.sv
`timescale 1ns / 1ps
// one valid/stall pipeline register with a payload of WIDTH bits
// no package dependencies
module a64ls_stage #(
  parameter int unsigned WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [WIDTH-1:0] data_o
);

  logic             valid_q, valid_d;
  logic [WIDTH-1:0] data_q;
  logic             load;

  // take a new request when empty or when the held one leaves this cycle
  assign stall_o = valid_q && stall_i;
  assign load    = valid_i && !stall_o;
  assign valid_d = load || (valid_q && stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/core/a64ls_classify.sv
`timescale 1ns / 1ps
// combinational class decode of one load/store instruction word
// depends on a64ls_pkg
module a64ls_classify (
  input  logic [a64ls_pkg::WordWidth-1:0] word_i,
  output a64ls_pkg::cls_e                 class_o
);

  logic [5:0] form;
  logic [1:0] size;
  logic       vec;
  logic [1:0] opc;
  logic       roff;
  a64ls_pkg::cls_e cls_excl, cls_lit, cls_pair, cls_reg, cls_plain;

  assign form = word_i[29:24];
  assign size = word_i[31:30];
  assign vec  = word_i[26];
  assign opc  = word_i[23:22];
  assign roff = word_i[21] && (word_i[11:10] == a64ls_pkg::OPTION_ROFF);

  // plain store or load once the special encodings are ruled out
  assign cls_plain = (opc == a64ls_pkg::OPC_STORE) ? a64ls_pkg::CLS_STORE
                                                   : a64ls_pkg::CLS_LOAD;

  always_comb begin
    if (word_i[21] && (word_i[14:10] != a64ls_pkg::RT_NONE)) begin
      cls_excl = a64ls_pkg::CLS_UNALLOC;
    end else if (word_i[21]) begin
      cls_excl = a64ls_pkg::CLS_CAS;
    end else if (!word_i[23]) begin
      cls_excl = word_i[22] ? a64ls_pkg::CLS_LDXR : a64ls_pkg::CLS_STXR;
    end else begin
      cls_excl = word_i[22] ? a64ls_pkg::CLS_LDAQ : a64ls_pkg::CLS_STRL;
    end
  end

  assign cls_lit = vec ? a64ls_pkg::CLS_UNMODEL : a64ls_pkg::CLS_LIT;

  always_comb begin
    if (size == a64ls_pkg::SIZE_DWORD) begin
      cls_pair = a64ls_pkg::CLS_UNALLOC;
    end else if (vec) begin
      cls_pair = a64ls_pkg::CLS_UNMODEL;
    end else begin
      cls_pair = word_i[22] ? a64ls_pkg::CLS_LDP : a64ls_pkg::CLS_STP;
    end
  end

  // register forms: bit 24 picks unsigned immediate, else offset or imm9
  always_comb begin
    priority if (!word_i[24] && roff && !word_i[14]) begin
      cls_reg = a64ls_pkg::CLS_UNALLOC;
    end else if (!word_i[24] && roff && !vec && opc == a64ls_pkg::OPC_SIGNED32
                 && size[1]) begin
      cls_reg = a64ls_pkg::CLS_UNALLOC;
    end else if (!word_i[24] && roff) begin
      cls_reg = vec ? a64ls_pkg::CLS_UNMODEL : cls_plain;
    end else if (size == a64ls_pkg::SIZE_DWORD && opc == a64ls_pkg::OPC_SIGNED64) begin
      // prefetch: nop in the unsigned immediate form
      cls_reg = word_i[24] ? a64ls_pkg::CLS_NOP : a64ls_pkg::CLS_UNMODEL;
    end else if (opc == a64ls_pkg::OPC_SIGNED32 && size[1]) begin
      cls_reg = a64ls_pkg::CLS_UNALLOC;
    end else if (vec) begin
      cls_reg = a64ls_pkg::CLS_UNMODEL;
    end else begin
      cls_reg = cls_plain;
    end
  end

  always_comb begin
    unique case (form)
      a64ls_pkg::FORM_EXCL:    class_o = cls_excl;
      a64ls_pkg::FORM_LIT_GP,
      a64ls_pkg::FORM_LIT_VEC: class_o = cls_lit;
      a64ls_pkg::FORM_PAIR_0,
      a64ls_pkg::FORM_PAIR_1,
      a64ls_pkg::FORM_PAIR_2,
      a64ls_pkg::FORM_PAIR_3:  class_o = cls_pair;
      a64ls_pkg::FORM_REG_0,
      a64ls_pkg::FORM_REG_1,
      a64ls_pkg::FORM_REG_2,
      a64ls_pkg::FORM_REG_3:   class_o = cls_reg;
      a64ls_pkg::FORM_SIMD_0,
      a64ls_pkg::FORM_SIMD_1:  class_o = a64ls_pkg::CLS_UNMODEL;
      default:                 class_o = a64ls_pkg::CLS_UNALLOC;
    endcase
  end

endmodule

### rtl/core/aarch64_ldst_class_decoder_core.sv
`timescale 1ns / 1ps
// top level of the load/store class decoder
// depends on a64ls_pkg, a64ls_stage and a64ls_classify
//
// usage
// - input channel: instruction_word_i with in_valid_i; a request is taken
//   at a rising edge where in_valid_i is high and in_stall_o is low
// - output channel: instruction_class_o with out_valid_o; a result leaves
//   at a rising edge where out_valid_o is high and out_stall_i is low
// - two register stages: the word register, then short decode logic, then
//   the class register
// - throughput is one request per cycle while the output is not stalled,
//   set by the single decode pass between the two registers; a new request
//   is taken while a finished class still waits at the output
// - a stalled receiver holds the class register; the word register keeps
//   filling, and in_stall_o rises only once both stages are occupied and
//   the output is stalled
// - reset (rst_ni low, asynchronous) empties both stages; only the two
//   valid flags are reset, so no clearing pass is needed
module aarch64_ldst_class_decoder_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [a64ls_pkg::WordWidth-1:0]   instruction_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [a64ls_pkg::ClassWidth-1:0]  instruction_class_o
);

  // word register
  logic                            word_valid;
  logic                            word_stall;
  logic [a64ls_pkg::WordWidth-1:0] word_q;

  // decoded class feeding the result register
  a64ls_pkg::cls_e                  class_d;
  logic [a64ls_pkg::ClassWidth-1:0] class_q;

  a64ls_stage #(
    .WIDTH (a64ls_pkg::WordWidth)
  ) u_word_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .data_i  (instruction_word_i),
    .valid_o (word_valid),
    .stall_i (word_stall),
    .data_o  (word_q)
  );

  a64ls_classify u_classify (
    .word_i  (word_q),
    .class_o (class_d)
  );

  a64ls_stage #(
    .WIDTH (a64ls_pkg::ClassWidth)
  ) u_class_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (word_valid),
    .stall_o (word_stall),
    .data_i  (class_d),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (class_q)
  );

  assign instruction_class_o = class_q;

  // input is held back only when both stages are full and output is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (word_valid && out_valid_o && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // a word that moves on always shows up as a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_valid && !word_stall) |=> out_valid_o)
    else $error("decoded request lost between stages");

  // result codes stay within the defined classes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (instruction_class_o <= a64ls_pkg::CLS_LDAQ))
    else $error("class code out of range");

  // simd structure forms always come out as unmodelled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_valid && !word_stall && (word_q[29:24] == a64ls_pkg::FORM_SIMD_0 ||
     word_q[29:24] == a64ls_pkg::FORM_SIMD_1))
    |=> (instruction_class_o == a64ls_pkg::CLS_UNMODEL))
    else $error("simd structure form not marked unmodelled");

endmodule
